/* sv/ebp_pkg.sv */
// Shared types and curve constants for the Ed25519 strict byte precheck.
package ebp_pkg;

   // One field element as seen by the byte checks: the low 255 bits of an encoding.
   typedef logic [254:0] ebp_fe_type;

   // A full 256-bit little-endian value, with word 0 in the low bits.
   typedef logic [255:0] ebp_word256_type;

   // Number of low-255-bit values that encode small-order points.
   localparam int TORSION_COUNT = 7;

   // Places in the torsion list that the canonical-sign check also needs.
   localparam int TY_ONE         = 1;
   localparam int TY_P_MINUS_ONE = 2;

   // Group order L = 2^252 + 27742317777372353535851937790883648493.
   localparam ebp_word256_type ORDER_L = {
      64'h1000000000000000, 64'h0000000000000000,
      64'h14def9dea2f79cd6, 64'h5812631a5cf5d3ed
   };

   // Field prime p = 2^255 - 19.
   localparam ebp_fe_type FIELD_P = {
      63'h7fffffffffffffff, 64'hffffffffffffffff,
      64'hffffffffffffffff, 64'hffffffffffffffed
   };

   // The seven encodings of the eight small-order points (sign bit excluded):
   // 0, 1, p-1, p, p+1, alpha and p-alpha.
   localparam ebp_fe_type TORSION_Y [TORSION_COUNT] = '{
      {63'h0000000000000000, 64'h0000000000000000,
       64'h0000000000000000, 64'h0000000000000000},
      {63'h0000000000000000, 64'h0000000000000000,
       64'h0000000000000000, 64'h0000000000000001},
      {63'h7fffffffffffffff, 64'hffffffffffffffff,
       64'hffffffffffffffff, 64'hffffffffffffffec},
      {63'h7fffffffffffffff, 64'hffffffffffffffff,
       64'hffffffffffffffff, 64'hffffffffffffffed},
      {63'h7fffffffffffffff, 64'hffffffffffffffff,
       64'hffffffffffffffff, 64'hffffffffffffffee},
      {63'h7a03ac9277fdc74e, 64'hc6cc392cfa53202a,
       64'h0f67100d760b3cba, 64'h4fd84d3d706a17c7},
      {63'h05fc536d880238b1, 64'h3933c6d305acdfd5,
       64'hf098eff289f4c345, 64'hb027b2c28f95e826}
   };

   // One request: public key A, then R and S of the signature.
   typedef struct packed {
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic [63:0] r_word0;
      logic [63:0] r_word1;
      logic [63:0] r_word2;
      logic [63:0] r_word3;
      logic [63:0] s_word0;
      logic [63:0] s_word1;
      logic [63:0] s_word2;
      logic [63:0] s_word3;
   } ebp_req_type;

   // One result: the overall verdict and one flag per failed rule.
   typedef struct packed {
      logic accept;
      logic scalar_too_large;
      logic key_small_order;
      logic r_small_order;
      logic r_noncanonical;
   } ebp_rsp_type;

   // Match status of one encoding against the torsion list.
   typedef struct packed {
      logic small_order;
      logic is_one;
      logic is_p_minus_one;
   } ebp_match_type;

endpackage

/* sv/ebp_torsion_match.sv */
// Compares one encoding against the small-order torsion encodings.
module ebp_torsion_match
   import ebp_pkg::*;
(
   input  ebp_fe_type    value,
   output ebp_match_type status
);

   logic [TORSION_COUNT-1:0] hit;

   // One equality compare per torsion encoding; the sign bit is not seen here.
   always_comb begin
      for (int i = 0; i < TORSION_COUNT; i++) begin
         hit[i] = (value == TORSION_Y[i]);
      end
   end

   // Any hit is small order; two of the hits also matter for the sign rule.
   always_comb begin
      status.small_order    = |hit;
      status.is_one         = hit[TY_ONE];
      status.is_p_minus_one = hit[TY_P_MINUS_ONE];
   end

endmodule

/* sv/ebp_scalar_check.sv */
// Range check of the signature scalar S against the group order.
module ebp_scalar_check
   import ebp_pkg::*;
(
   input  ebp_word256_type scalar,
   output logic            too_large
);

   // S must be strictly below L; all 256 bits take part in the compare.
   assign too_large = (scalar >= ORDER_L);

endmodule

/* sv/ed25519_strict_byte_precheck.sv */
// Top level of the Ed25519 strict byte precheck: request register, checks, result register.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   ebp_req_type: key A, R and S words
//   rsp_      out         rsp_valid/rsp_stall   ebp_rsp_type: accept and four flags
//
// A request is registered on entry and its result is then registered in the result register,
// which drives rsp_; one request per cycle while rsp_stall does not hold the pipeline.
// The compares against constants between the two registers set the cycle time.
// Reset clears both valid bits; the payload registers are not reset.
// While a result waits under rsp_stall the whole pipeline holds, and req_stall is raised.
module ed25519_strict_byte_precheck
   import ebp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ebp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ebp_rsp_type rsp_data
);

   logic            advance;
   logic            in_valid_ff;
   ebp_req_type     in_ff;
   logic            out_valid_ff;
   ebp_rsp_type     out_ff;
   ebp_rsp_type     out_in;
   ebp_fe_type      key_value;
   ebp_word256_type r_value;
   ebp_word256_type s_value;
   ebp_match_type   key_status;
   ebp_match_type   r_status;
   logic            s_too_large;
   logic            r_at_or_above_p;
   logic            r_bad_sign;

   // The pipeline moves whenever the result register is empty or being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Reassemble the little-endian words into full values; the key's sign bit plays no part.
   assign key_value = {in_ff.key_word3[62:0], in_ff.key_word2, in_ff.key_word1,
                       in_ff.key_word0};
   assign r_value   = {in_ff.r_word3, in_ff.r_word2, in_ff.r_word1, in_ff.r_word0};
   assign s_value   = {in_ff.s_word3, in_ff.s_word2, in_ff.s_word1, in_ff.s_word0};

   ebp_torsion_match u_key_match (
      .value  (key_value),
      .status (key_status)
   );

   ebp_torsion_match u_r_match (
      .value  (r_value[254:0]),
      .status (r_status)
   );

   ebp_scalar_check u_scalar_check (
      .scalar    (s_value),
      .too_large (s_too_large)
   );

   // R must be a reduced field element, and the sign bit is forbidden on y = 1 and y = p-1.
   assign r_at_or_above_p = (r_value[254:0] >= FIELD_P);
   assign r_bad_sign      = r_value[255] && (r_status.is_one || r_status.is_p_minus_one);

   // Collect the flags; the request passes only when none is set.
   always_comb begin
      out_in.scalar_too_large = s_too_large;
      out_in.key_small_order  = key_status.small_order;
      out_in.r_small_order    = r_status.small_order;
      out_in.r_noncanonical   = r_at_or_above_p || r_bad_sign;
      out_in.accept           = !(s_too_large || key_status.small_order ||
                                  r_status.small_order || r_at_or_above_p || r_bad_sign);
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Ed25519 strict byte precheck.
module tb_top;
   import ebp_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_REQUESTS = 900;
   localparam int HOLD_AT         = 600;
   localparam int HOLD_CYCLES     = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Curve constants kept apart from the package so that a wrong package value shows up.
   localparam logic [254:0] PRIME = {63'h7fffffffffffffff, 64'hffffffffffffffff,
                                     64'hffffffffffffffff, 64'hffffffffffffffed};
   localparam logic [254:0] ALPHA = {63'h7a03ac9277fdc74e, 64'hc6cc392cfa53202a,
                                     64'h0f67100d760b3cba, 64'h4fd84d3d706a17c7};
   localparam logic [255:0] GROUP_ORDER = {64'h1000000000000000, 64'h0000000000000000,
                                           64'h14def9dea2f79cd6, 64'h5812631a5cf5d3ed};
   localparam logic [254:0] SMALL_ORDER_Y [7] = '{
      255'd0, 255'd1, PRIME - 255'd1, PRIME, PRIME + 255'd1, ALPHA, PRIME - ALPHA
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ebp_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ebp_rsp_type rsp_data;

   // Set by the stimulus process while neither side may idle.
   bit calm = 1'b0;

   // Keeps the verdicts still owed by the block and checks each one as it arrives.
   class precheck_scoreboard;
      ebp_rsp_type owed[$];
      int requests_noted = 0;
      int failures = 0;
      int accepted_total = 0;
      int large_scalars = 0;
      int small_keys = 0;
      int small_rs = 0;
      int bad_rs = 0;

      function bit small_order_y(logic [254:0] y);
         bit hit;
         hit = 1'b0;
         foreach (SMALL_ORDER_Y[i])
            if (y == SMALL_ORDER_Y[i]) hit = 1'b1;
         return hit;
      endfunction

      // Works out the verdict that the block must give for one request.
      function ebp_rsp_type predict_verdict(ebp_req_type rq);
         logic [255:0] key;
         logic [255:0] sig_r;
         logic [255:0] sig_s;
         ebp_rsp_type  v;
         key   = {rq.key_word3, rq.key_word2, rq.key_word1, rq.key_word0};
         sig_r = {rq.r_word3, rq.r_word2, rq.r_word1, rq.r_word0};
         sig_s = {rq.s_word3, rq.s_word2, rq.s_word1, rq.s_word0};
         v.scalar_too_large = sig_s >= GROUP_ORDER;
         v.key_small_order  = small_order_y(key[254:0]);
         v.r_small_order    = small_order_y(sig_r[254:0]);
         // R is rejected when its y is not reduced, or when it is a negative 1 or p-1.
         v.r_noncanonical   = (sig_r[254:0] >= PRIME) ||
                              (sig_r[255] && (sig_r[254:0] == 255'd1 ||
                                              sig_r[254:0] == PRIME - 255'd1));
         v.accept = !(v.scalar_too_large || v.key_small_order ||
                      v.r_small_order || v.r_noncanonical);
         return v;
      endfunction

      function void note_request(ebp_req_type rq);
         owed.push_back(predict_verdict(rq));
         requests_noted++;
      endfunction

      function void compare_flag(string name, logic want, logic got);
         if (got !== want) begin
            $error("%s: expected %b, got %b", name, want, got);
            failures++;
         end
      endfunction

      function void check_verdict(ebp_rsp_type got);
         ebp_rsp_type want;
         if (owed.size() == 0) begin
            $error("verdict %b arrived with no request outstanding", got);
            failures++;
            return;
         end
         want = owed.pop_front();
         compare_flag("accept", want.accept, got.accept);
         compare_flag("scalar_too_large", want.scalar_too_large, got.scalar_too_large);
         compare_flag("key_small_order", want.key_small_order, got.key_small_order);
         compare_flag("r_small_order", want.r_small_order, got.r_small_order);
         compare_flag("r_noncanonical", want.r_noncanonical, got.r_noncanonical);
         accepted_total += want.accept;
         large_scalars  += want.scalar_too_large;
         small_keys     += want.key_small_order;
         small_rs       += want.r_small_order;
         bad_rs         += want.r_noncanonical;
      endfunction
   endclass

   precheck_scoreboard sb = new();

   ed25519_strict_byte_precheck u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [255:0] rand256();
      return {$urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   // A positive, reduced y that is almost surely not a torsion encoding.
   function automatic logic [255:0] good_point();
      logic [255:0] v;
      v = rand256();
      v[255] = 1'b0;
      v[254] = 1'b0;
      return v;
   endfunction

   // Random point encoding: mostly arbitrary, some torsion values, some near p.
   function automatic logic [255:0] pick_point();
      int  kind;
      bit  sign;
      kind = $urandom_range(0, 99);
      sign = $urandom_range(0, 1);
      if (kind < 70) return rand256();
      if (kind < 85) return {sign, SMALL_ORDER_Y[$urandom_range(0, 6)]};
      return {sign, PRIME - 255'd3 + 255'($urandom_range(0, 15))};
   endfunction

   // Random scalar: mostly below L, some close to L on either side, some arbitrary or extreme.
   function automatic logic [255:0] pick_scalar();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 55) return rand256() >> 4;
      if (kind < 75) return GROUP_ORDER - 256'd4 + 256'($urandom_range(0, 8));
      if (kind < 95) return rand256();
      return $urandom_range(0, 1) ? '1 : '0;
   endfunction

   // Packs key, R and S into one request; word 0 of each value is its low 64 bits.
   function automatic ebp_req_type make_request(logic [255:0] a, logic [255:0] r,
                                                logic [255:0] s);
      return {a[63:0], a[127:64], a[191:128], a[255:192],
              r[63:0], r[127:64], r[191:128], r[255:192],
              s[63:0], s[127:64], s[191:128], s[255:192]};
   endfunction

   // Offers one request, with an occasional gap first, and returns once it is taken.
   task automatic send_request(ebp_req_type rq);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(rq);
   endtask

   // Receiver: random stalls, plus one long hold-off to fill the pipeline.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.requests_noted >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_verdict(rsp_data);
   end

   // Watchdog on cycles in which neither channel moves a request or a verdict.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Timed out with %0d verdicts outstanding", sb.owed.size());
      $display("FAIL ed25519_strict_byte_precheck");
      $finish;
   end

   // Stimulus: directed corners first, then random requests.
   initial begin
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A clean signature that passes every rule.
      send_request(make_request(good_point(), good_point(), rand256() >> 4));
      // Every torsion y as the key; the sign bit must not matter.
      for (i = 0; i < 7; i++)
         send_request(make_request({i[0], SMALL_ORDER_Y[i]}, good_point(), 256'd0));
      // Every torsion y as R, with both signs.
      for (i = 0; i < 14; i++)
         send_request(make_request(good_point(), {i[0], SMALL_ORDER_Y[i / 2]},
                                   rand256() >> 4));
      // Scalar just below and at the group order, and the all-ones extreme.
      send_request(make_request(good_point(), good_point(), GROUP_ORDER - 256'd1));
      send_request(make_request(good_point(), good_point(), GROUP_ORDER));
      send_request(make_request('1, good_point(), '1));
      // R edges: largest 255-bit y, and a negative reduced y just below p-1.
      send_request(make_request(good_point(), '1, 256'd5));
      send_request(make_request(good_point(), {1'b1, PRIME - 255'd2}, 256'd5));
      // Every flag at once.
      send_request(make_request(256'd0, {1'b1, PRIME}, '1));

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         calm = (i >= 300 && i < 450);
         send_request(make_request(pick_point(), pick_point(), pick_scalar()));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d requests under random stalls and one long receiver hold-off.",
               sb.requests_noted);
      $display("Verdicts: %0d accepted, %0d large S, %0d small-order A,",
               sb.accepted_total, sb.large_scalars, sb.small_keys);
      $display("          %0d small-order R, %0d non-canonical R.",
               sb.small_rs, sb.bad_rs);
      if (sb.failures == 0 && sb.owed.size() == 0) begin
         $display("PASS ed25519_strict_byte_precheck");
      end else begin
         $display("FAIL ed25519_strict_byte_precheck");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ebp_pkg.sv
sv/ebp_torsion_match.sv
sv/ebp_scalar_check.sv
sv/ed25519_strict_byte_precheck.sv
bench/tb_top.sv
